// ===== hw/rtl/quaternion_slerp_defines.svh =====
// Assertion helpers for the checker file qs_checker.sv.
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define QS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define QS_ASSERT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qs_pkg.sv =====
package qs_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;

    // square root: 32 steps cover a 64-bit radicand
    localparam int SQRT_STEPS = 32;
    // CORDIC datapath word
    localparam int QS_CW      = 34;
    // angle in Q30 radians, below 2^31
    localparam int QS_ANG_W   = 31;
    // magnitudes of the weighted sum, below 2^48
    localparam int MAG_W      = 48;
    localparam int NORM_STEPS = 6;
    // divider quotient bits and compare width
    localparam int Q_BITS     = FRAC_BITS + 3;
    localparam int CMP_W      = 32 + Q_BITS;

    localparam logic [63:0] ONE_Q30  = 64'(1) << 30;
    localparam logic [63:0] ONE_SQ   = 64'(1) << 60;
    localparam logic [63:0] ONE_DOT  = 64'(1) << (2 * FRAC_BITS);
    localparam int          DOT_SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int          DOT_SH_L = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

    localparam logic signed [15:0] ONE_OUT =
        (FRAC_BITS >= 15) ? 16'sh7FFF : 16'(1 << FRAC_BITS);

    localparam logic CORDIC_ROT = 1'b0;
    localparam logic CORDIC_VEC = 1'b1;

    // atan(2^-i) in Q30
    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

    // per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] bp;
        logic [16:0]      t;
        logic [30:0]      c;
        logic             bad;
        logic             szero;
        logic             azero;
        logic             zsum;
        logic [3:0]       neg;
        logic [3:0][29:0] mg;
    } t_side;

    typedef struct packed {
        logic signed [QS_CW-1:0] x;
        logic signed [QS_CW-1:0] y;
        logic signed [QS_CW-1:0] z;
    } t_cst;

endpackage

// ===== hw/rtl/qs_if.sv =====
interface qs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [17:0] weight;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, weight,
                    input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, weight,
                    output ready);
endinterface

interface qs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               bad_weight;

    modport source (output valid, out_w, out_x, out_y, out_z, bad_weight, input ready);
    modport sink   (input valid, out_w, out_x, out_y, out_z, bad_weight, output ready);
endinterface

// ===== hw/rtl/qs_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qs_isqrt import qs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_root
);

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } t_sq;

    t_sq r_st [SQRT_STEPS];

    function automatic t_sq sq_step(input t_sq s, input int k);
        t_sq         o;
        logic [63:0] bb;
        bb = 64'(1) << (62 - 2 * k);
        if (s.n >= s.r + bb) begin
            o.n = s.n - (s.r + bb);
            o.r = (s.r >> 1) + bb;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= sq_step('{n: i_n, r: 64'd0}, 0);
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_st[k] <= sq_step(r_st[k-1], k);
            end
        end
    end

    assign o_root = r_st[SQRT_STEPS-1].r[31:0];

endmodule

// ===== hw/rtl/qs_cordic.sv =====
// Pipelined CORDIC, vectoring or rotation, one iteration per stage.
module qs_cordic import qs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_vec,
    input  logic signed [QS_CW-1:0] i_x,
    input  logic signed [QS_CW-1:0] i_y,
    input  logic signed [QS_CW-1:0] i_z,
    output logic signed [QS_CW-1:0] o_x,
    output logic signed [QS_CW-1:0] o_y,
    output logic signed [QS_CW-1:0] o_z
);

    t_cst r_st [CORDIC_STAGES];

    function automatic t_cst cstep(input t_cst s, input logic vec, input int i);
        t_cst                    o;
        logic                    up;
        logic signed [QS_CW-1:0] dx;
        logic signed [QS_CW-1:0] dy;
        logic signed [QS_CW-1:0] at;
        dx = s.y >>> i;
        dy = s.x >>> i;
        at = QS_CW'(ATAN_Q30[i[4:0]]);
        // vectoring drives y to zero, rotation drives z to zero
        up = (vec == CORDIC_VEC) ? s.y[QS_CW-1] : !s.z[QS_CW-1];
        if (up) begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - at;
        end else begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + at;
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= cstep('{x: i_x, y: i_y, z: i_z}, i_vec, 0);
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                r_st[i] <= cstep(r_st[i-1], i_vec, i);
            end
        end
    end

    assign o_x = r_st[CORDIC_STAGES-1].x;
    assign o_y = r_st[CORDIC_STAGES-1].y;
    assign o_z = r_st[CORDIC_STAGES-1].z;

endmodule

// ===== hw/rtl/quaternion_slerp.sv =====
// Quaternion slerp pipeline. Each input beat carries quaternions A and B (signed Q1.14)
// and a weight t (signed Q1.16); each output beat is slerp(A, B, t) renormalized to unit
// length, in Q1.14. One beat is accepted every clock cycle unless the output stalls; results
// leave in order. The latency is set by the two 32-step square roots (sine of the angle,
// then the norm), the vectoring and rotation CORDIC chains, and the restoring divider
// that makes one quotient bit per stage. A stall on the output freezes the whole pipe in
// place, so nothing is dropped or repeated; the input is ready whenever the output
// register is empty or being drained. A weight outside 0..1 gives the identity with
// bad_weight set; a zero angle returns A unchanged; a zero weighted sum returns zero.
module quaternion_slerp import qs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qs_in_if.sink    i_in,
    qs_out_if.source o_out
);

    localparam int LAT = 6 + SQRT_STEPS + CORDIC_STAGES + 3 + CORDIC_STAGES + 4
                       + NORM_STEPS + 3 + SQRT_STEPS + 1 + Q_BITS + 1;

    // global advance: the pipe moves when the output slot can take a beat
    logic           w_en;
    logic [LAT-1:0] r_vld;

    // front end: products, dot, cosine, radicand
    t_side              n1_sd, r1_sd, r2_sd, r3_sd, n4_sd, r4_sd, r5_sd, r6_sd;
    logic signed [31:0] r2_p [4];
    logic signed [33:0] r3_dot;
    logic [32:0]        w_abs;
    logic [63:0]        w_cl64;
    logic [63:0]        w_c64;
    logic [30:0]        w_c;
    logic [61:0]        r5_cc;
    logic [63:0]        r6_n;

    // sine, angle, split angles
    t_side                   r_q1 [SQRT_STEPS];
    logic [31:0]             w_s;
    t_side                   n_c1;
    t_side                   r_c1 [CORDIC_STAGES];
    logic signed [QS_CW-1:0] w_vz;
    logic [QS_ANG_W-1:0]     w_ang;
    t_side                   n7_sd, r7_sd, r8_sd, r9_sd;
    logic [QS_ANG_W-1:0]     r7_ang, r8_ang, r8_phib, r9_pa, r9_pb;
    logic [47:0]             w_tprod;
    t_side                   r_c2 [CORDIC_STAGES];
    logic signed [QS_CW-1:0] w_ya, w_yb;
    logic signed [31:0]      w_sa, w_sb;

    // weighted sum and normalization
    t_side              r10_sd, r11_sd, n12_sd, r12_sd, n13_sd;
    logic signed [49:0] r10_pa [4];
    logic signed [49:0] r10_pb [4];
    logic signed [49:0] r11_r [4];
    logic [MAG_W-1:0]   r12_mag [4];
    logic [MAG_W-1:0]   w_m01, w_m23, w_m;
    t_side              r_ns [NORM_STEPS+1];
    logic [MAG_W-1:0]   r_nm [NORM_STEPS+1];
    logic [MAG_W-1:0]   r_nmag [NORM_STEPS+1][4];
    t_side              n14_sd, r14_sd, r15_sd, r16_sd;
    logic [59:0]        r15_sq [4];
    logic [63:0]        r16_n;
    t_side              r_q2 [SQRT_STEPS];
    logic [31:0]        w_nrm;

    // divider; index 0 is the setup register
    t_side            r_ds [Q_BITS+1];
    logic [31:0]      r_dd [Q_BITS+1];
    logic [CMP_W-1:0] r_drem [Q_BITS+1][4];
    logic [Q_BITS-1:0] r_dq [Q_BITS+1][4];

    // output register
    logic signed [15:0] n_ow [4];
    logic signed [15:0] r_ow [4];
    logic               r_obad;

    assign w_en        = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // ---- stage 1: capture, range check on t ----
    always_comb begin
        n1_sd       = '0;
        n1_sd.a[0]  = i_in.a_w;
        n1_sd.a[1]  = i_in.a_x;
        n1_sd.a[2]  = i_in.a_y;
        n1_sd.a[3]  = i_in.a_z;
        n1_sd.bp[0] = 17'(i_in.b_w);
        n1_sd.bp[1] = 17'(i_in.b_x);
        n1_sd.bp[2] = 17'(i_in.b_y);
        n1_sd.bp[3] = 17'(i_in.b_z);
        n1_sd.t     = i_in.weight[16:0];
        n1_sd.bad   = (i_in.weight < 18'sd0) || (i_in.weight > 18'sd65536);
    end

    // ---- stage 4: |dot|, clamp at one, move to Q30; flip B on a negative dot ----
    always_comb begin
        w_abs  = 33'(r3_dot[33] ? -r3_dot : r3_dot);
        w_cl64 = (64'(w_abs) > ONE_DOT) ? ONE_DOT : 64'(w_abs);
        w_c64  = (w_cl64 >> DOT_SH_R) << DOT_SH_L;
        w_c    = (w_c64 > ONE_Q30) ? ONE_Q30[30:0] : w_c64[30:0];
        n4_sd   = r3_sd;
        n4_sd.c = w_c;
        for (int k = 0; k < 4; k++) begin
            if (r3_dot[33]) begin
                n4_sd.bp[k] = -r3_sd.bp[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sd <= n1_sd;
            for (int k = 0; k < 4; k++) begin
                r2_p[k] <= $signed(r1_sd.a[k]) * $signed(r1_sd.bp[k][15:0]);
            end
            r2_sd  <= r1_sd;
            r3_dot <= 34'(r2_p[0]) + 34'(r2_p[1]) + 34'(r2_p[2]) + 34'(r2_p[3]);
            r3_sd  <= r2_sd;
            r4_sd  <= n4_sd;
            r5_cc  <= r4_sd.c * r4_sd.c;
            r5_sd  <= r4_sd;
            r6_n   <= ONE_SQ - 64'(r5_cc);
            r6_sd  <= r5_sd;
        end
    end

    // ---- sine = sqrt(1 - cos^2) ----
    qs_isqrt u_sqrt_sin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (r6_n),
        .o_root (w_s)
    );

    always_comb begin
        n_c1       = r_q1[SQRT_STEPS-1];
        n_c1.szero = (w_s == 32'd0);
    end

    // ---- angle = atan2(sine, cos) ----
    qs_cordic u_cordic_ang (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (CORDIC_VEC),
        .i_x   (QS_CW'(r_q1[SQRT_STEPS-1].c)),
        .i_y   (QS_CW'(w_s)),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (w_vz)
    );

    always_comb begin
        w_ang       = w_vz[QS_CW-1] ? '0 : w_vz[QS_ANG_W-1:0];
        n7_sd       = r_c1[CORDIC_STAGES-1];
        n7_sd.azero = n7_sd.szero || (w_ang == '0);
        w_tprod     = 48'(r7_ang) * 48'(r7_sd.t);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q1[0] <= r6_sd;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_q1[k] <= r_q1[k-1];
            end
            r_c1[0] <= n_c1;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_c1[k] <= r_c1[k-1];
            end
            r7_ang  <= w_ang;
            r7_sd   <= n7_sd;
            r8_ang  <= r7_ang;
            r8_phib <= w_tprod[QS_ANG_W+15:16];
            r8_sd   <= r7_sd;
            r9_pa   <= r8_ang - r8_phib;
            r9_pb   <= r8_phib;
            r9_sd   <= r8_sd;
            r_c2[0] <= r9_sd;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_c2[k] <= r_c2[k-1];
            end
        end
    end

    // ---- sA = sin(angle - phiB), sB = sin(phiB), gain left in ----
    qs_cordic u_cordic_sa (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (CORDIC_ROT),
        .i_x   (QS_CW'(ONE_Q30)),
        .i_y   ('0),
        .i_z   (QS_CW'(r9_pa)),
        .o_x   (),
        .o_y   (w_ya),
        .o_z   ()
    );

    qs_cordic u_cordic_sb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (CORDIC_ROT),
        .i_x   (QS_CW'(ONE_Q30)),
        .i_y   ('0),
        .i_z   (QS_CW'(r9_pb)),
        .o_x   (),
        .o_y   (w_yb),
        .o_z   ()
    );

    assign w_sa = w_ya[31:0];
    assign w_sb = w_yb[31:0];

    // ---- magnitudes and their maximum ----
    always_comb begin
        n12_sd = r11_sd;
        for (int k = 0; k < 4; k++) begin
            n12_sd.neg[k] = r11_r[k][49];
        end
        w_m01 = (r12_mag[0] > r12_mag[1]) ? r12_mag[0] : r12_mag[1];
        w_m23 = (r12_mag[2] > r12_mag[3]) ? r12_mag[2] : r12_mag[3];
        w_m   = (w_m01 > w_m23) ? w_m01 : w_m23;
        n13_sd      = r12_sd;
        n13_sd.zsum = (w_m == '0);
    end

    // ---- left-normalize so the largest magnitude has its top bit set ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r10_pa[k]  <= w_sa * $signed(r_c2[CORDIC_STAGES-1].a[k]);
                r10_pb[k]  <= w_sb * $signed(r_c2[CORDIC_STAGES-1].bp[k]);
                r11_r[k]   <= r10_pa[k] + r10_pb[k];
                r12_mag[k] <= MAG_W'(r11_r[k][49] ? -r11_r[k] : r11_r[k]);
                r_nmag[0][k] <= r12_mag[k];
            end
            r10_sd  <= r_c2[CORDIC_STAGES-1];
            r11_sd  <= r10_sd;
            r12_sd  <= n12_sd;
            r_nm[0] <= w_m;
            r_ns[0] <= n13_sd;
            for (int j = 1; j <= NORM_STEPS; j++) begin
                if ((r_nm[j-1] >> (MAG_W - (1 << (NORM_STEPS - j)))) == '0) begin
                    r_nm[j] <= r_nm[j-1] << (1 << (NORM_STEPS - j));
                    for (int k = 0; k < 4; k++) begin
                        r_nmag[j][k] <= r_nmag[j-1][k] << (1 << (NORM_STEPS - j));
                    end
                end else begin
                    r_nm[j] <= r_nm[j-1];
                    for (int k = 0; k < 4; k++) begin
                        r_nmag[j][k] <= r_nmag[j-1][k];
                    end
                end
                r_ns[j] <= r_ns[j-1];
            end
        end
    end

    // keep 30 bits: the largest lands in [2^29, 2^30)
    always_comb begin
        n14_sd = r_ns[NORM_STEPS];
        for (int k = 0; k < 4; k++) begin
            n14_sd.mg[k] = r_nmag[NORM_STEPS][k][MAG_W-1 -: 30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r14_sd <= n14_sd;
            for (int k = 0; k < 4; k++) begin
                r15_sq[k] <= r14_sd.mg[k] * r14_sd.mg[k];
            end
            r15_sd <= r14_sd;
            r16_n  <= 64'(r15_sq[0]) + 64'(r15_sq[1]) + 64'(r15_sq[2]) + 64'(r15_sq[3]);
            r16_sd <= r15_sd;
            r_q2[0] <= r16_sd;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_q2[k] <= r_q2[k-1];
            end
        end
    end

    // ---- norm ----
    qs_isqrt u_sqrt_nrm (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (r16_n),
        .o_root (w_nrm)
    );

    // ---- restoring divide: (mag << FRAC_BITS + nrm/2) / nrm, MSB first ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds[0] <= r_q2[SQRT_STEPS-1];
            r_dd[0] <= (w_nrm == 32'd0) ? 32'd1 : w_nrm;
            for (int k = 0; k < 4; k++) begin
                r_drem[0][k] <= (CMP_W'(r_q2[SQRT_STEPS-1].mg[k]) << FRAC_BITS)
                              + CMP_W'(w_nrm >> 1);
                r_dq[0][k]   <= '0;
            end
            for (int j = 1; j <= Q_BITS; j++) begin
                r_ds[j] <= r_ds[j-1];
                r_dd[j] <= r_dd[j-1];
                for (int k = 0; k < 4; k++) begin
                    if (r_drem[j-1][k] >= (CMP_W'(r_dd[j-1]) << (Q_BITS - j))) begin
                        r_drem[j][k] <= r_drem[j-1][k]
                                      - (CMP_W'(r_dd[j-1]) << (Q_BITS - j));
                        r_dq[j][k]   <= r_dq[j-1][k] | (Q_BITS'(1) << (Q_BITS - j));
                    end else begin
                        r_drem[j][k] <= r_drem[j-1][k];
                        r_dq[j][k]   <= r_dq[j-1][k];
                    end
                end
            end
        end
    end

    // ---- final select: bad weight, zero angle, zero sum, normal ----
    always_comb begin
        logic [16:0] qc;
        for (int k = 0; k < 4; k++) begin
            qc = (64'(r_dq[Q_BITS][k]) > 64'd65536) ? 17'd65536 : 17'(r_dq[Q_BITS][k]);
            priority if (r_ds[Q_BITS].bad) begin
                n_ow[k] = (k == 0) ? ONE_OUT : 16'sd0;
            end else if (r_ds[Q_BITS].azero) begin
                n_ow[k] = r_ds[Q_BITS].a[k];
            end else if (r_ds[Q_BITS].zsum) begin
                n_ow[k] = 16'sd0;
            end else if (r_ds[Q_BITS].neg[k]) begin
                n_ow[k] = (qc > 17'd32768) ? -16'sd32768 : 16'(-qc);
            end else begin
                n_ow[k] = (qc > 17'd32767) ? 16'sd32767 : 16'(qc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_ow[k] <= n_ow[k];
            end
            r_obad <= r_ds[Q_BITS].bad;
        end
    end

    assign o_out.out_w      = r_ow[0];
    assign o_out.out_x      = r_ow[1];
    assign o_out.out_y      = r_ow[2];
    assign o_out.out_z      = r_ow[3];
    assign o_out.bad_weight = r_obad;

endmodule

// ===== hw/rtl/qs_checker.sv =====
`include "quaternion_slerp_defines.svh"

module qs_checker import qs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_out_w,
    input logic signed [15:0] i_out_x,
    input logic signed [15:0] i_out_y,
    input logic signed [15:0] i_out_z,
    input logic               i_out_bad
);

    // stalled result beat holds
    `QS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_w) && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_bad), "stalled result beat changed")

    // input side never blocks while the output slot is free
    `QS_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready, "input held off with free output slot")

    // out-of-range weight gives the identity
    `QS_ASSERT_NOW(a_bad_ident, i_clk, i_rst_n, i_out_valid && i_out_bad, i_out_w == ONE_OUT && i_out_x == 16'sd0 && i_out_y == 16'sd0 && i_out_z == 16'sd0, "bad weight without identity result")

    // reset empties the pipe
    `QS_ASSERT_RAW(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result beat right after reset")

endmodule

bind quaternion_slerp qs_checker u_qs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_w     (o_out.out_w),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_out_bad   (o_out.bad_weight)
);

// ===== test/slerp_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts each slerp result and compares in order.
module slerp_checker import qs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    qs_in_if     i_in,
    qs_out_if    i_out,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_checked,
    output int   o_bad_seen
);

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               bad;
    } slerp_res_t;

    slerp_res_t quat_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring: angle of (x, y), gain left in
    function automatic longint angle_of(longint x, longint y);
        longint z = 0;
        longint dx, dy;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    // rotation from (1, 0): sine scaled by the CORDIC gain
    function automatic longint gain_sine(longint z);
        longint x = longint'(ONE_Q30);
        longint y = 0;
        longint dx, dy;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        return y;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic slerp_res_t slerp_predict(longint a[4], longint b[4], longint t);
        slerp_res_t res;
        longint dot = 0;
        longint c, s, ang, phi_a, phi_b, s_a, s_b, r;
        longint unsigned mag[4];
        longint unsigned m = 0, sum = 0, nrm, q;
        logic neg[4];
        longint v[4];

        res = '0;
        if (t < 0 || t > 65536) begin
            res.w = ONE_OUT;
            res.bad = 1'b1;
            return res;
        end
        for (int k = 0; k < 4; k++) dot += a[k] * b[k];
        // shorter arc: flip B
        if (dot < 0) begin
            dot = -dot;
            for (int k = 0; k < 4; k++) b[k] = -b[k];
        end
        if (dot > longint'(ONE_DOT)) dot = longint'(ONE_DOT);
        if (2 * FRAC_BITS >= 30) c = dot >>> DOT_SH_R;
        else                     c = dot <<  DOT_SH_L;
        if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
        s = longint'(int_sqrt(ONE_SQ - longint'(c) * longint'(c)));
        ang = (s == 0) ? 0 : angle_of(c, s);
        if (s == 0 || ang == 0) begin
            res.w = 16'(a[0]); res.x = 16'(a[1]); res.y = 16'(a[2]); res.z = 16'(a[3]);
            return res;
        end
        phi_b = (ang * t) >>> 16;
        phi_a = ang - phi_b;
        s_a = gain_sine(phi_a);
        s_b = gain_sine(phi_b);
        for (int k = 0; k < 4; k++) begin
            r = s_a * a[k] + s_b * b[k];
            neg[k] = r < 0;
            mag[k] = neg[k] ? longint'(-r) : longint'(r);
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) return res;
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int k = 0; k < 4; k++) mag[k] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int k = 0; k < 4; k++) mag[k] <<= 1;
        end
        for (int k = 0; k < 4; k++) sum += mag[k] * mag[k];
        nrm = int_sqrt(sum);
        if (nrm == 0) nrm = 1;
        for (int k = 0; k < 4; k++) begin
            q = ((mag[k] << FRAC_BITS) + (nrm >> 1)) / nrm;
            if (q > 65536) q = 65536;
            v[k] = neg[k] ? -longint'(q) : longint'(q);
        end
        res.w = sat16(v[0]); res.x = sat16(v[1]); res.y = sat16(v[2]); res.z = sat16(v[3]);
        return res;
    endfunction

    assign o_pending = quat_q.size();

    always @(posedge i_clk) begin
        longint a[4], b[4];
        slerp_res_t exp_res, got;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
            o_checked  <= 0;
            o_bad_seen <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                a = '{i_in.a_w, i_in.a_x, i_in.a_y, i_in.a_z};
                b = '{i_in.b_w, i_in.b_x, i_in.b_y, i_in.b_z};
                quat_q.push_back(slerp_predict(a, b, longint'(i_in.weight)));
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.out_w, i_out.out_x, i_out.out_y, i_out.out_z, i_out.bad_weight};
                if (quat_q.size() == 0) begin
                    if (o_fail_cnt < 10)
                        $display("unexpected result beat: %p", got);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_res = quat_q.pop_front();
                    if (got !== exp_res) begin
                        if (o_fail_cnt < 10)
                            $display("mismatch: expected %p, got %p", exp_res, got);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                    if (got.bad) o_bad_seen <= o_bad_seen + 1;
                end
                o_checked <= o_checked + 1;
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import qs_pkg::*;

    localparam int N_RANDOM   = 1500;
    localparam int LATENCY    = 137;
    localparam int STALL_LIM  = 4000;  // idle cycles before the watchdog fires
    localparam int HOLD_START = 400;   // cycle where the long output hold-off starts
    localparam int HOLD_LEN   = 500;   // longer than the pipe is deep

    logic i_clk;
    logic i_rst_n;
    int   cyc;
    int   idle_cyc;
    int   fail_cnt, pending, checked, bad_seen;
    logic calm;  // no input idling while set

    qs_in_if  in_ch ();
    qs_out_if out_ch ();

    quaternion_slerp u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    slerp_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_bad_seen (bad_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle count and watchdog on beats of either channel
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= STALL_LIM) begin
            $display("watchdog: no beat for %0d cycles", idle_cyc);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, a calm window, one long hold-off so the pipe fills
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                out_ch.ready <= 1'b0;
            else if (calm)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= 22);
        end
    end

    // one input beat; valid stays high when the next beat follows directly
    task automatic send_quat(input logic [15:0] aw, ax, ay, az, bw, bx, by, bz,
                             input logic [17:0] t);
        if (!calm) begin
            while ($urandom_range(99) < 22) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.a_w    <= aw; in_ch.a_x <= ax; in_ch.a_y <= ay; in_ch.a_z <= az;
        in_ch.b_w    <= bw; in_ch.b_x <= bx; in_ch.b_y <= by; in_ch.b_z <= bz;
        in_ch.weight <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] half_rand();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    initial begin
        logic [15:0] q[8];
        int sel, wait_cnt;
        cyc = 0;
        idle_cyc = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.a_w <= '0; in_ch.a_x <= '0; in_ch.a_y <= '0; in_ch.a_z <= '0;
        in_ch.b_w <= '0; in_ch.b_x <= '0; in_ch.b_y <= '0; in_ch.b_z <= '0;
        in_ch.weight <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: weight limits and just outside them
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd0);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd65536);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd32768);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, -18'sd1);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd65537);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, -18'sd131072);
        send_quat(16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 0, 18'sd131071);
        // zero angle: A equal to B, and A opposite B
        send_quat(16'sd11585, 16'sd11585, 0, 0, 16'sd11585, 16'sd11585, 0, 0, 18'sd20000);
        send_quat(0, 16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 18'sd40000);
        // zero sum: both quaternions zero
        send_quat(0, 0, 0, 0, 0, 0, 0, 0, 18'sd30000);
        // component extremes, dot clamps past one
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                  16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 18'sd50000);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                  -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 18'sd1);
        send_quat(-16'sd32768, 0, 0, 0, 16'sd32767, 0, 0, 0, 18'sd65535);
        send_quat(0, 0, 16'sd16384, 0, 0, 0, 0, 16'sd16384, 18'sd10000);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192,
                  -16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 18'sd45000);
        // negative dot flips B
        send_quat(16'sd16384, 0, 0, 0, -16'sd11585, -16'sd11585, 0, 0, 18'sd16384);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 600 && n < 900);
            sel = $urandom_range(99);
            for (int k = 0; k < 4; k++) q[k] = half_rand();
            if (sel < 15) begin
                // noise: any bits in every field
                for (int k = 0; k < 8; k++) q[k] = 16'($urandom);
                send_quat(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], 18'($urandom));
            end else if (sel < 35) begin
                // B close to A: small angles
                for (int k = 0; k < 4; k++) q[4 + k] = q[k] + 16'($urandom_range(64) - 32);
                send_quat(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7],
                          18'($urandom_range(65536)));
            end else begin
                for (int k = 4; k < 8; k++) q[k] = half_rand();
                send_quat(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7],
                          18'($urandom_range(65536)));
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        wait_cnt = 0;
        while (wait_cnt < 2 * LATENCY) begin
            @(posedge i_clk);
            wait_cnt++;
        end

        $display("covered %0d slerp beats (%0d with an out-of-range weight), directed limits,",
                 checked, bad_seen);
        $display("random stalls on both sides and a %0d-cycle output hold-off", HOLD_LEN);
        if (fail_cnt == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
